// ----- rtl/core/utp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types, character codes and form-check helpers for the UUID text
// parser.
// ----------------------------------------------------------------------------
package utp_pkg;

    localparam int POS_W = 6;

    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;
    localparam logic [3:0] HEX_ALPHA_BASE = 4'hA;

    localparam int BARE_LEN   = 32;
    localparam int HYPHEN_LEN = 36;
    localparam int BRACE_LEN  = 38;
    localparam int POS_MAX    = 63;

    localparam logic [POS_W-1:0] HYPHEN_SLOT_0 = POS_W'(8);
    localparam logic [POS_W-1:0] HYPHEN_SLOT_1 = POS_W'(13);
    localparam logic [POS_W-1:0] HYPHEN_SLOT_2 = POS_W'(18);
    localparam logic [POS_W-1:0] HYPHEN_SLOT_3 = POS_W'(23);

    typedef struct packed {
        logic       is_hex;
        logic [3:0] digit;
        logic       is_hyphen;
        logic       is_lbrace;
        logic       is_rbrace;
    } t_char_class;

    typedef struct packed {
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic        parsed_ok;
    } t_parse_result;

    function automatic logic is_hyphen_slot(input logic [POS_W-1:0] p);
        return (p == HYPHEN_SLOT_0) || (p == HYPHEN_SLOT_1) ||
               (p == HYPHEN_SLOT_2) || (p == HYPHEN_SLOT_3);
    endfunction

    // Character check for the hyphenated layout at position p.
    function automatic logic hyphen_char_ok(input logic [POS_W-1:0] p,
                                            input t_char_class cls);
        return is_hyphen_slot(p) ? cls.is_hyphen : cls.is_hex;
    endfunction

endpackage

// ----- rtl/core/utp_char_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_char_decode
// Classifies one ASCII character: hex digit value and the punctuation marks
// used by the UUID text forms.
// ----------------------------------------------------------------------------
module utp_char_decode (
    input  logic [7:0]           i_char_code,
    output utp_pkg::t_char_class o_class
);

    logic       w_dec;
    logic       w_low;
    logic       w_up;
    logic [7:0] w_off;

    always_comb begin
        w_dec = (i_char_code >= utp_pkg::CHAR_ZERO)  && (i_char_code <= utp_pkg::CHAR_NINE);
        w_low = (i_char_code >= utp_pkg::CHAR_LOW_A) && (i_char_code <= utp_pkg::CHAR_LOW_F);
        w_up  = (i_char_code >= utp_pkg::CHAR_UP_A)  && (i_char_code <= utp_pkg::CHAR_UP_F);

        priority if (w_dec) begin
            w_off = i_char_code - utp_pkg::CHAR_ZERO;
        end else if (w_low) begin
            w_off = i_char_code - utp_pkg::CHAR_LOW_A;
        end else if (w_up) begin
            w_off = i_char_code - utp_pkg::CHAR_UP_A;
        end else begin
            w_off = 8'd0;
        end

        o_class.is_hex    = w_dec | w_low | w_up;
        o_class.digit     = w_dec ? w_off[3:0]
                          : ((w_low | w_up) ? (utp_pkg::HEX_ALPHA_BASE + w_off[3:0]) : 4'd0);
        o_class.is_hyphen = (i_char_code == utp_pkg::CHAR_HYPHEN);
        o_class.is_lbrace = (i_char_code == utp_pkg::CHAR_LBRACE);
        o_class.is_rbrace = (i_char_code == utp_pkg::CHAR_RBRACE);
    end

endmodule

// ----- rtl/core/utp_form_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_form_tracker
// Holds the digit shift register, position counter and per-form match flags,
// and forms the parse result for the final character.
// ----------------------------------------------------------------------------
module utp_form_tracker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_last_char,
    input  utp_pkg::t_char_class   i_class,
    output utp_pkg::t_parse_result o_result
);

    localparam int POS_W = utp_pkg::POS_W;

    logic [127:0]     r_shift;
    logic [POS_W-1:0] r_pos;
    logic             r_bare_ok;
    logic             r_hyph_ok;
    logic             r_brace_ok;

    logic [127:0]     n_shift;
    logic [POS_W-1:0] n_pos;
    logic             n_bare_ok;
    logic             n_hyph_ok;
    logic             n_brace_ok;
    logic [POS_W:0]   w_len;
    logic             w_ok;

    always_comb begin
        n_shift = i_class.is_hex ? {r_shift[123:0], i_class.digit} : r_shift;

        n_bare_ok = r_bare_ok;
        if ((r_pos < POS_W'(utp_pkg::BARE_LEN)) && !i_class.is_hex) begin
            n_bare_ok = 1'b0;
        end

        n_hyph_ok = r_hyph_ok;
        if ((r_pos < POS_W'(utp_pkg::HYPHEN_LEN)) &&
            !utp_pkg::hyphen_char_ok(r_pos, i_class)) begin
            n_hyph_ok = 1'b0;
        end

        // Brace form: '{', then the hyphenated layout shifted by one, then '}'.
        n_brace_ok = r_brace_ok;
        priority if (r_pos == '0) begin
            if (!i_class.is_lbrace) n_brace_ok = 1'b0;
        end else if (r_pos == POS_W'(utp_pkg::BRACE_LEN - 1)) begin
            if (!i_class.is_rbrace) n_brace_ok = 1'b0;
        end else if (r_pos < POS_W'(utp_pkg::BRACE_LEN - 1)) begin
            if (!utp_pkg::hyphen_char_ok(r_pos - POS_W'(1), i_class)) n_brace_ok = 1'b0;
        end else begin
            n_brace_ok = r_brace_ok;
        end

        n_pos = (r_pos < POS_W'(utp_pkg::POS_MAX)) ? r_pos + POS_W'(1) : r_pos;

        w_len = {1'b0, r_pos} + (POS_W+1)'(1);
        w_ok  = ((w_len == (POS_W+1)'(utp_pkg::BARE_LEN))   && n_bare_ok) ||
                ((w_len == (POS_W+1)'(utp_pkg::HYPHEN_LEN)) && n_hyph_ok) ||
                ((w_len == (POS_W+1)'(utp_pkg::BRACE_LEN))  && n_brace_ok);

        o_result.uuid_high = w_ok ? n_shift[127:64] : 64'd0;
        o_result.uuid_low  = w_ok ? n_shift[63:0]   : 64'd0;
        o_result.parsed_ok = w_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= '0;
            r_pos      <= '0;
            r_bare_ok  <= 1'b1;
            r_hyph_ok  <= 1'b1;
            r_brace_ok <= 1'b1;
        end else if (i_accept) begin
            if (i_last_char) begin
                r_shift    <= '0;
                r_pos      <= '0;
                r_bare_ok  <= 1'b1;
                r_hyph_ok  <= 1'b1;
                r_brace_ok <= 1'b1;
            end else begin
                r_shift    <= n_shift;
                r_pos      <= n_pos;
                r_bare_ok  <= n_bare_ok;
                r_hyph_ok  <= n_hyph_ok;
                r_brace_ok <= n_brace_ok;
            end
        end
    end

endmodule

// ----- rtl/core/uuid_text_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuid_text_parser_unit
// Parses UUID text (bare, hyphenated or braced) one character per
// transaction and returns the 128-bit value on the final character.
// ----------------------------------------------------------------------------
// The result is registered: valid in the cycle after the final character is accepted.
// Throughput: one character per cycle while o_stall is low; the decode and
// shift logic ahead of the output register is combinational.
// A final character waits only while a previous result is held by the sink.
// Reset (synchronous, active low) clears the parser state and the output valid.
// ----------------------------------------------------------------------------
module uuid_text_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_uuid_high,
    output logic [63:0] o_uuid_low,
    output logic        o_parsed_ok
);

    utp_pkg::t_char_class   w_class;
    utp_pkg::t_parse_result w_result;
    logic                   w_accept;

    logic                   r_out_valid;
    utp_pkg::t_parse_result r_out;

    // Only a final character needs the output slot.
    assign o_stall  = r_out_valid & i_stall & i_last_char;
    assign w_accept = i_valid & ~o_stall;

    utp_char_decode u_decode (
        .i_char_code (i_char_code),
        .o_class     (w_class)
    );

    utp_form_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_last_char (i_last_char),
        .i_class     (w_class),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_char) begin
            r_out <= w_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_uuid_high = r_out.uuid_high;
    assign o_uuid_low  = r_out.uuid_low;
    assign o_parsed_ok = r_out.parsed_ok;

endmodule
